/* design/ip6tp_pkg.sv */
`default_nettype none

package ip6tp_pkg;

    // One character of address text
    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_char_item;

    // One parse result
    typedef struct packed {
        logic        valid_res;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_addr_item;

    localparam int unsigned NUM_GROUPS = 8;

endpackage

`default_nettype wire

/* design/ipv6_address_text_parser.sv */
// The result is registered: it reaches the output register in the cycle after the
// character flagged last is accepted. Throughput: one character per cycle unless
// o_in_stall holds the input; each character updates the small parse registers and
// the final group compaction is fixed muxing in the same cycle.
// Reset (i_rst_n low, synchronous) clears all parse state and o_out_valid.
`default_nettype none

module ipv6_address_text_parser (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  ip6tp_pkg::t_char_item   i_in_item,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    output ip6tp_pkg::t_addr_item   o_out_item,
    output logic                    o_out_valid,
    input  wire                     i_out_stall
);
    import ip6tp_pkg::*;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_LEAD  = 3'd1;
    localparam logic [2:0] PH_PIECE = 3'd2;
    localparam logic [2:0] PH_SEP   = 3'd3;
    localparam logic [2:0] PH_DEC   = 3'd4;
    localparam logic [2:0] PH_FAIL  = 3'd5;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // parse state
    logic [15:0] r_groups [NUM_GROUPS];
    logic [3:0]  r_gi;
    logic [3:0]  r_ci;
    logic        r_seen;
    logic [15:0] r_hex;
    logic [2:0]  r_dc;
    logic [7:0]  r_dec;
    logic        r_usable;
    logic [1:0]  r_dot;
    logic [2:0]  r_phase;

    // state after this character
    logic [15:0] s_groups [NUM_GROUPS];
    logic [3:0]  s_gi;
    logic [3:0]  s_ci;
    logic        s_seen;
    logic [15:0] s_hex;
    logic [2:0]  s_dc;
    logic [7:0]  s_dec;
    logic        s_usable;
    logic [1:0]  s_dot;
    logic [2:0]  s_phase;

    logic        r_out_valid;
    t_addr_item  r_out_item;
    t_addr_item  n_out_item;

    logic        accept;
    logic [7:0]  c;
    logic        is_dec, is_hex, is_colon, is_dot;
    logic [3:0]  nib;
    logic [11:0] dec_v;
    logic        dec_bad;
    logic        do_piece, do_compress, do_dec;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign c        = i_in_item.char_code;
    assign is_dec   = (c >= 8'h30) && (c <= 8'h39);
    assign is_hex   = is_dec || ((c >= 8'h61) && (c <= 8'h66)) ||
                      ((c >= 8'h41) && (c <= 8'h46));
    assign nib      = is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);
    assign is_colon = (c == CH_COLON);
    assign is_dot   = (c == CH_DOT);
    assign dec_v    = ({4'd0, r_dec} << 3) + ({4'd0, r_dec} << 1) + {8'd0, c[3:0]};
    assign dec_bad  = ((r_dc != 3'd0) && (r_dec == 8'd0)) || (dec_v > 12'd255);

    // one character step
    always_comb begin
        s_groups    = r_groups;
        s_gi        = r_gi;
        s_ci        = r_ci;
        s_seen      = r_seen;
        s_hex       = r_hex;
        s_dc        = r_dc;
        s_dec       = r_dec;
        s_usable    = r_usable;
        s_dot       = r_dot;
        s_phase     = r_phase;
        do_piece    = 1'b0;
        do_compress = 1'b0;
        do_dec      = 1'b0;

        unique case (r_phase)
            PH_START: begin
                if (is_colon) begin
                    s_phase = PH_LEAD;
                end else begin
                    s_phase  = PH_PIECE;
                    do_piece = 1'b1;
                end
            end
            PH_LEAD: begin
                if (is_colon) begin
                    s_phase     = PH_PIECE;
                    do_compress = 1'b1;
                end else begin
                    s_phase = PH_FAIL;
                end
            end
            PH_PIECE, PH_SEP: begin
                s_phase  = PH_PIECE;
                do_piece = 1'b1;
            end
            PH_DEC: begin
                do_dec = 1'b1;
            end
            default: begin
                s_phase = PH_FAIL;
            end
        endcase

        if (do_piece) begin
            priority if (r_dc == 3'd0 && r_gi >= 4'd8) begin
                s_phase = PH_FAIL;
            end else if (r_dc == 3'd0 && is_colon) begin
                do_compress = 1'b1;
            end else if (is_hex && r_dc < 3'd4) begin
                s_hex = {r_hex[11:0], nib};
                if (is_dec) begin
                    if (r_usable) begin
                        if (dec_bad) begin
                            s_usable = 1'b0;
                        end else begin
                            s_dec = dec_v[7:0];
                        end
                    end
                end else begin
                    s_usable = 1'b0;
                end
                s_dc = 3'(r_dc + 3'd1);
            end else if (is_dot) begin
                if (r_dc == 3'd0 || r_gi > 4'd6 || !r_usable) begin
                    s_phase = PH_FAIL;
                end else begin
                    s_groups[r_gi[2:0]] = {8'd0, r_dec};
                    s_dot    = 2'd1;
                    s_hex    = '0;
                    s_dc     = '0;
                    s_dec    = '0;
                    s_usable = 1'b1;
                    s_phase  = PH_DEC;
                end
            end else if (is_colon && r_dc != 3'd0) begin
                s_groups[r_gi[2:0]] = r_hex;
                s_gi     = 4'(r_gi + 4'd1);
                s_hex    = '0;
                s_dc     = '0;
                s_dec    = '0;
                s_usable = 1'b1;
                s_phase  = PH_SEP;
            end else begin
                s_phase = PH_FAIL;
            end
        end

        if (do_compress) begin
            if (r_seen) begin
                s_phase = PH_FAIL;
            end else begin
                s_gi   = 4'(r_gi + 4'd1);
                s_ci   = 4'(r_gi + 4'd1);
                s_seen = 1'b1;
            end
        end

        if (do_dec) begin
            priority if (is_dec) begin
                if (dec_bad) begin
                    s_phase = PH_FAIL;
                end else begin
                    s_dec = dec_v[7:0];
                    s_dc  = 3'(r_dc + 3'd1);
                end
            end else if (is_dot && r_dc != 3'd0 && r_dot < 2'd3) begin
                // second and fourth numbers close a group
                s_groups[r_gi[2:0]] = {r_groups[r_gi[2:0]][7:0], r_dec};
                if (r_dot[0]) begin
                    s_gi = 4'(r_gi + 4'd1);
                end
                s_hex    = '0;
                s_dc     = '0;
                s_dec    = '0;
                s_usable = 1'b1;
                s_dot    = 2'(r_dot + 2'd1);
            end else begin
                s_phase = PH_FAIL;
            end
        end
    end

    // end of text: close the open number, then slide the groups after the
    // compression point to the end, filling the gap with zeros
    logic [15:0] f_groups [NUM_GROUPS];
    logic [15:0] p_groups [NUM_GROUPS];
    logic [3:0]  f_gi;
    logic        f_bad;
    logic        f_ok;
    logic [3:0]  gap;
    logic [4:0]  gap_end;

    always_comb begin
        f_groups = s_groups;
        f_gi     = s_gi;
        f_bad    = 1'b0;
        if (s_phase == PH_PIECE) begin
            if (s_dc != 3'd0) begin
                f_groups[s_gi[2:0]] = s_hex;
                f_gi = 4'(s_gi + 4'd1);
            end
        end else if (s_phase == PH_DEC) begin
            if (s_dc == 3'd0 || s_dot != 2'd3) begin
                f_bad = 1'b1;
            end else begin
                f_groups[s_gi[2:0]] = {s_groups[s_gi[2:0]][7:0], s_dec};
                f_gi = 4'(s_gi + 4'd1);
            end
        end else begin
            f_bad = 1'b1;
        end
        f_ok = !f_bad && (s_seen || (f_gi == 4'd8));
    end

    assign gap     = 4'(4'd8 - f_gi);
    assign gap_end = {1'b0, s_ci} + {1'b0, gap};

    always_comb begin
        for (int k = 0; k < NUM_GROUPS; k++) begin
            if (!s_seen || 5'(k) < {1'b0, s_ci}) begin
                p_groups[k] = f_groups[k];
            end else if (5'(k) < gap_end) begin
                p_groups[k] = '0;
            end else begin
                p_groups[k] = f_groups[3'(3'(k) - gap[2:0])];
            end
        end
        n_out_item.valid_res = f_ok;
        n_out_item.addr_high = f_ok ? {p_groups[0], p_groups[1], p_groups[2], p_groups[3]}
                                    : 64'd0;
        n_out_item.addr_low  = f_ok ? {p_groups[4], p_groups[5], p_groups[6], p_groups[7]}
                                    : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_GROUPS; k++) begin
                r_groups[k] <= '0;
            end
            r_gi     <= '0;
            r_ci     <= '0;
            r_seen   <= 1'b0;
            r_hex    <= '0;
            r_dc     <= '0;
            r_dec    <= '0;
            r_usable <= 1'b1;
            r_dot    <= '0;
            r_phase  <= PH_START;
        end else if (accept) begin
            if (i_in_item.last) begin
                for (int k = 0; k < NUM_GROUPS; k++) begin
                    r_groups[k] <= '0;
                end
                r_gi     <= '0;
                r_ci     <= '0;
                r_seen   <= 1'b0;
                r_hex    <= '0;
                r_dc     <= '0;
                r_dec    <= '0;
                r_usable <= 1'b1;
                r_dot    <= '0;
                r_phase  <= PH_START;
            end else begin
                r_groups <= s_groups;
                r_gi     <= s_gi;
                r_ci     <= s_ci;
                r_seen   <= s_seen;
                r_hex    <= s_hex;
                r_dc     <= s_dc;
                r_dec    <= s_dec;
                r_usable <= s_usable;
                r_dot    <= s_dot;
                r_phase  <= s_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_in_item.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.last) begin
            r_out_item <= n_out_item;
        end
    end

    // a rejected address carries a zero address
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.valid_res) |->
            (r_out_item.addr_high == 64'd0 && r_out_item.addr_low == 64'd0))
        else $error("invalid result with nonzero address");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_item.last) |=>
            (r_phase == PH_START && r_gi == 4'd0 && !r_seen && r_out_valid))
        else $error("state not cleared or no result after last item");

    a_gi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gi <= 4'd8) && (r_dc <= 3'd4))
        else $error("group index or digit count out of range");

    a_ci_le_gi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_ci != 4'd0 && r_ci <= r_gi))
        else $error("compression point beyond group index");

    a_no_result_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(accept && i_in_item.last)) |=> !r_out_valid)
        else $error("result without last item");

endmodule

`default_nettype wire

/* tb/ipv6_address_result_check.sv */
`default_nettype none

module ipv6_address_result_check (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  ip6tp_pkg::t_char_item i_in_item,
    input  wire                   i_in_valid,
    input  wire                   i_in_stall,
    input  ip6tp_pkg::t_addr_item i_out_item,
    input  wire                   i_out_valid,
    input  wire                   i_out_stall,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ip6tp_pkg::*;

    typedef enum logic [2:0] {
        PS_START,
        PS_LEAD,
        PS_PIECE,
        PS_SEP,
        PS_DEC,
        PS_FAIL
    } t_parse_phase;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam int         OCTET_MAX = 255;

    // parse state of the text in flight
    logic [15:0]  grp [NUM_GROUPS];
    logic [3:0]   grp_idx;
    logic [3:0]   zc_idx;
    logic         zc_seen;
    logic [15:0]  hex_acc;
    logic [2:0]   hex_digits;
    logic [9:0]   dec_acc;
    logic         dec_ok;
    logic [1:0]   dots;
    t_parse_phase phase;

    t_addr_item addr_expect_q[$];
    int         fails = 0;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    task clear_number();
        hex_acc    = '0;
        hex_digits = '0;
        dec_acc    = '0;
        dec_ok     = 1'b1;
    endtask

    task clear_parse();
        for (int i = 0; i < NUM_GROUPS; i++) grp[i] = '0;
        grp_idx = '0;
        zc_idx  = '0;
        zc_seen = 1'b0;
        clear_number();
        dots  = '0;
        phase = PS_START;
    endtask

    task take_zero_run();
        if (zc_seen) begin
            phase = PS_FAIL;
        end else begin
            grp_idx = grp_idx + 1'b1;
            zc_idx  = grp_idx;
            zc_seen = 1'b1;
        end
    endtask

    task piece_char(input logic [7:0] c);
        int h;
        int v;
        h = hex_nibble(c);
        if (hex_digits == 0 && grp_idx >= NUM_GROUPS) begin
            phase = PS_FAIL;
        end else if (hex_digits == 0 && c == CH_COLON) begin
            take_zero_run();
        end else if (h >= 0 && hex_digits < 4) begin
            hex_acc = {hex_acc[11:0], h[3:0]};
            if (c >= CH_ZERO && c <= CH_NINE) begin
                // track whether this piece could still be the first IPv4 octet
                if (dec_ok) begin
                    v = int'(dec_acc) * 10 + (int'(c) - int'(CH_ZERO));
                    if ((hex_digits > 0 && dec_acc == 0) || v > OCTET_MAX) dec_ok = 1'b0;
                    else dec_acc = v[9:0];
                end
            end else begin
                dec_ok = 1'b0;
            end
            hex_digits = hex_digits + 1'b1;
        end else if (c == CH_DOT) begin
            if (hex_digits == 0 || grp_idx > 6 || !dec_ok) begin
                phase = PS_FAIL;
            end else begin
                grp[grp_idx[2:0]] = {6'd0, dec_acc};
                dots = 2'd1;
                clear_number();
                phase = PS_DEC;
            end
        end else if (c == CH_COLON && hex_digits > 0) begin
            grp[grp_idx[2:0]] = hex_acc;
            grp_idx = grp_idx + 1'b1;
            clear_number();
            phase = PS_SEP;
        end else begin
            phase = PS_FAIL;
        end
    endtask

    // second and fourth octet complete a group
    task close_octet();
        logic [2:0] i;
        i = grp_idx[2:0];
        grp[i] = {grp[i][7:0], dec_acc[7:0]};
        if (dots[0]) grp_idx = grp_idx + 1'b1;
        clear_number();
    endtask

    task dec_char(input logic [7:0] c);
        int v;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = int'(dec_acc) * 10 + (int'(c) - int'(CH_ZERO));
            if ((hex_digits > 0 && dec_acc == 0) || v > OCTET_MAX) begin
                phase = PS_FAIL;
            end else begin
                dec_acc    = v[9:0];
                hex_digits = hex_digits + 1'b1;
            end
        end else if (c == CH_DOT && hex_digits > 0 && dots < 3) begin
            close_octet();
            dots = dots + 1'b1;
        end else begin
            phase = PS_FAIL;
        end
    endtask

    task close_text(output bit ok);
        int          shifts;
        int          slot;
        int          j;
        logic [15:0] t;
        ok = 1'b0;
        if (phase == PS_PIECE) begin
            if (hex_digits > 0) begin
                grp[grp_idx[2:0]] = hex_acc;
                grp_idx = grp_idx + 1'b1;
            end
            ok = 1'b1;
        end else if (phase == PS_DEC) begin
            if (hex_digits > 0 && dots == 3) begin
                close_octet();
                ok = 1'b1;
            end
        end
        if (ok) begin
            if (zc_seen) begin
                // move the groups after the "::" to the tail of the address
                shifts = (grp_idx >= zc_idx) ? int'(grp_idx) - int'(zc_idx) : 0;
                slot   = 7;
                while (slot != 0 && shifts > 0) begin
                    j         = (int'(zc_idx) + shifts - 1) & 7;
                    t         = grp[slot];
                    grp[slot] = grp[j];
                    grp[j]    = t;
                    slot--;
                    shifts--;
                end
            end else begin
                ok = (grp_idx == NUM_GROUPS);
            end
        end
    endtask

    task parse_char(input logic [7:0] c, input logic is_last,
                    output bit has_addr, output t_addr_item addr);
        bit ok;
        has_addr = 1'b0;
        addr     = '0;
        case (phase)
            PS_START: begin
                if (c == CH_COLON) begin
                    phase = PS_LEAD;
                end else begin
                    phase = PS_PIECE;
                    piece_char(c);
                end
            end
            PS_LEAD: begin
                if (c == CH_COLON) begin
                    phase = PS_PIECE;
                    take_zero_run();
                end else begin
                    phase = PS_FAIL;
                end
            end
            PS_PIECE, PS_SEP: begin
                phase = PS_PIECE;
                piece_char(c);
            end
            PS_DEC: begin
                dec_char(c);
            end
            default: begin
                phase = PS_FAIL;
            end
        endcase
        if (is_last) begin
            close_text(ok);
            if (ok) begin
                addr.valid_res = 1'b1;
                addr.addr_high = {grp[0], grp[1], grp[2], grp[3]};
                addr.addr_low  = {grp[4], grp[5], grp[6], grp[7]};
            end
            has_addr = 1'b1;
            clear_parse();
        end
    endtask

    initial clear_parse();

    always @(posedge i_clk) begin
        bit         has_addr;
        t_addr_item want;
        if (!i_rst_n) begin
            clear_parse();
            addr_expect_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                parse_char(i_in_item.char_code, i_in_item.last, has_addr, want);
                if (has_addr) addr_expect_q.insert(addr_expect_q.size(), want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (addr_expect_q.size() == 0) begin
                    $display("%0t: unexpected result item, actual %h", $time, i_out_item);
                    fails++;
                end else begin
                    want = addr_expect_q.pop_front();
                    if (i_out_item.valid_res !== want.valid_res) begin
                        $display("%0t: valid_res expected %b actual %b",
                                 $time, want.valid_res, i_out_item.valid_res);
                        fails++;
                    end
                    if (i_out_item.addr_high !== want.addr_high) begin
                        $display("%0t: addr_high expected %h actual %h",
                                 $time, want.addr_high, i_out_item.addr_high);
                        fails++;
                    end
                    if (i_out_item.addr_low !== want.addr_low) begin
                        $display("%0t: addr_low expected %h actual %h",
                                 $time, want.addr_low, i_out_item.addr_low);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= addr_expect_q.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

/* tb/tb_ipv6_address_text_parser.sv */
`default_nettype none

module tb_ipv6_address_text_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import ip6tp_pkg::*;

    localparam int RANDOM_CHARS = 2000;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 10;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    t_char_item in_item   = '0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_addr_item out_item;
    logic       out_valid;
    logic       out_stall = 1'b0;

    int fail_count;
    int pending;

    t_char_item char_q[$];
    logic [7:0] text_buf[$];

    int next_idx       = 0;
    int chars_accepted = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    int idle_cycles    = 0;

    logic [15:0] stall_mask = '0;
    logic [7:0]  stall_age  = '0;

    // 4 ns period
    always #2 clk = ~clk;

    ipv6_address_text_parser DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_item  (in_item),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .o_out_item (out_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall)
    );

    ipv6_address_result_check u_result_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_item   (in_item),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_out_item  (out_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    task put_char(input logic [7:0] ch);
        text_buf.insert(text_buf.size(), ch);
    endtask

    task put_str(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    // one text goes out with last on its final character
    task flush_text();
        t_char_item item;
        for (int i = 0; i < text_buf.size(); i++) begin
            item.char_code = text_buf[i];
            item.last      = (i == text_buf.size() - 1);
            char_q.insert(char_q.size(), item);
        end
        text_buf.delete();
    endtask

    task add_text(input string s);
        put_str(s);
        flush_text();
    endtask

    task put_hex_group();
        string digits;
        int    n;
        digits = "0123456789abcdefABCDEF";
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) put_char(digits[$urandom_range(0, 21)]);
    endtask

    task put_v4();
        bit sloppy;
        int v;
        sloppy = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < 4; i++) begin
            if (i > 0) put_str(".");
            v = sloppy ? $urandom_range(0, 300) : $urandom_range(0, 255);
            if (sloppy && $urandom_range(0, 3) == 0) put_str("0");
            put_str($sformatf("%0d", v));
        end
    endtask

    task build_address();
        bit with_v4;
        bit zc;
        int max_grp;
        int ngrp;
        int zc_at;
        with_v4 = ($urandom_range(0, 3) == 0);
        max_grp = with_v4 ? 6 : 8;
        zc      = ($urandom_range(0, 2) != 0);
        // ngrp may exceed the room left by "::" now and then
        ngrp    = zc ? $urandom_range(0, max_grp) : max_grp;
        zc_at   = $urandom_range(0, ngrp);
        for (int i = 0; i <= ngrp; i++) begin
            if (zc && i == zc_at) put_str("::");
            else if (i > 0 && (i < ngrp || with_v4)) put_str(":");
            if (i < ngrp) put_hex_group();
            else if (with_v4) put_v4();
        end
    endtask

    task mangle();
        string odd;
        int    pos;
        int    len;
        odd = ":.0xX-+ g9";
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 4))
            0: text_buf[pos] = 8'($urandom_range(0, 255));
            1: text_buf.insert(pos, odd[$urandom_range(0, odd.len() - 1)]);
            2: if (text_buf.size() > 1) text_buf.delete(pos);
            3: begin
                len = $urandom_range(1, text_buf.size());
                while (text_buf.size() > len) text_buf.delete(text_buf.size() - 1);
            end
            default: put_str(".");
        endcase
    endtask

    task build_noise();
        string alpha;
        int    n;
        alpha = "0123456789abcdefABCDEF:.";
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1)) put_char(alpha[$urandom_range(0, 23)]);
            else put_char(8'($urandom_range(0, 255)));
        end
    endtask

    task make_stimulus();
        int start_size;
        int pick;
        add_text("::");
        add_text("::1");
        add_text("1::");
        add_text(":::");
        add_text("1:2:3:4:5:6:7:8");
        add_text("ffff:FFFF:0:0:0000:aBcD:0:ffff");
        add_text("1:2:3:4:5:6:7:8:9");
        add_text("1:2:3:4:5:6:7::");
        add_text("::2:3:4:5:6:7:8");
        add_text("1:2:3:4:5:6:7:8::");
        add_text("1::2:3:4:5:6:7:8");
        add_text("1::2::3");
        add_text(":1::");
        add_text("1:");
        add_text("0x1::");
        add_text("12345::");
        add_text("-1::");
        add_text("+1::");
        add_text("::ffff:192.168.0.1");
        add_text("1:2:3:4:5:6:255.255.255.255");
        add_text("1:2:3:4:5:6:7:0.0.0.0");
        add_text("::1.2.3.4.");
        add_text("::01.2.3.4");
        add_text("::256.1.1.1");
        add_text("::1.2.3");
        add_text("::1.2.3.4.5");
        add_text("::a1.2.3.4");
        add_text("7");
        put_str("::1");
        put_char(8'h00);
        flush_text();
        put_str("1");
        put_char(8'hFF);
        flush_text();

        start_size = char_q.size();
        while (char_q.size() < start_size + RANDOM_CHARS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                build_noise();
            end else begin
                build_address();
                if (pick < 35) mangle();
            end
            flush_text();
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) chars_accepted <= chars_accepted + 1;
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (next_idx < char_q.size()) begin
                    in_item  <= char_q[next_idx];
                    in_valid <= 1'b1;
                    next_idx <= next_idx + 1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall follows a 16-bit mask, redrawn as stall_age wraps; bit 0 stays clear
    always @(posedge clk) begin
        stall_age <= stall_age + 1'b1;
        if (stall_age == 0) begin
            stall_mask <= ($urandom_range(0, 3) == 0) ? 16'h0000
                                                      : (16'($urandom()) & 16'hFFFE);
        end
        out_stall <= stall_mask[stall_age[3:0]];
    end

    always @(posedge clk) begin
        if (!rst_n) idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        make_stimulus();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (idle_cycles < IDLE_LIMIT
               && !(chars_accepted == char_q.size() && pending == 0)) begin
            @(posedge clk);
        end
        if (idle_cycles < IDLE_LIMIT) repeat (TAIL_CYCLES) @(posedge clk);
        if (idle_cycles < IDLE_LIMIT && pending == 0 && fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
design/ip6tp_pkg.sv
design/ipv6_address_text_parser.sv
tb/ipv6_address_result_check.sv
tb/tb_ipv6_address_text_parser.sv
